// File: src/owtr_pkg.sv
// Package for the single-wire temperature reader: shared types, command
// bytes, register indexes and small helper functions.
// No dependencies.
package owtr_pkg;

   // Bus sequencer phases.
   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_RST_LOW   = 4'd1,
      PH_RST_REL   = 4'd2,
      PH_WR_LOW    = 4'd3,
      PH_WR_DATA   = 4'd4,
      PH_WR_REC    = 4'd5,
      PH_CONV_WAIT = 4'd6,
      PH_RD_LOW    = 4'd7,
      PH_RD_WAIT   = 4'd8,
      PH_RD_TAIL   = 4'd9
   } phase_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;
   localparam int TIMER_W     = 20;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_START_LOW     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RESET_LOW     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_RESET_RELEASE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_WRITE_DATA    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SLOT_RECOVERY = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_READ_SAMPLE   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_READ_TAIL     = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_CONVERT_WAIT  = 3'd7;

   // Bus command bytes.
   localparam logic [7:0] CMD_SKIP_ROM     = 8'hCC;
   localparam logic [7:0] CMD_CONVERT      = 8'h44;
   localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

   typedef struct packed {
      logic [3:0]         start_low_time;
      logic [9:0]         reset_low_time;
      logic [9:0]         reset_release_time;
      logic [9:0]         write_data_time;
      logic [9:0]         slot_recovery_time;
      logic [3:0]         read_sample_time;
      logic [9:0]         read_tail_time;
      logic [TIMER_W-1:0] convert_wait_time;
   } cfg_type;

   typedef struct packed {
      logic        drive_low;
      logic        busy_res;
      logic        done_res;
      logic [15:0] raw_reading;
      logic [15:0] tenths_degrees;
   } result_type;

   // Timer load for a phase of the given length; a zero length still
   // occupies one tick.
   function automatic logic [TIMER_W-1:0] enter_len(input logic [TIMER_W-1:0] len);
      enter_len = (len == '0) ? '0 : len - 1'b1;
   endfunction

   // Command byte sent in position idx of the command sequence.
   function automatic logic [7:0] cmd_byte(input logic [1:0] idx);
      case (idx)
         2'd0:    cmd_byte = CMD_SKIP_ROM;
         2'd1:    cmd_byte = CMD_CONVERT;
         2'd2:    cmd_byte = CMD_SKIP_ROM;
         2'd3:    cmd_byte = CMD_READ_SCRATCH;
         default: cmd_byte = CMD_SKIP_ROM;
      endcase
   endfunction

endpackage

// File: src/owtr_csr.sv
// Configuration register file of the temperature reader.
// Depends on owtr_pkg for register indexes and the configuration struct.
module owtr_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [owtr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [owtr_pkg::CSR_DATA_W-1:0]    csr_data,
   output owtr_pkg::cfg_type                  cfg
);
   import owtr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Each write keeps only the low bits that fit its register.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_START_LOW:     cfg_in.start_low_time     = csr_data[3:0];
            REG_RESET_LOW:     cfg_in.reset_low_time     = csr_data[9:0];
            REG_RESET_RELEASE: cfg_in.reset_release_time = csr_data[9:0];
            REG_WRITE_DATA:    cfg_in.write_data_time    = csr_data[9:0];
            REG_SLOT_RECOVERY: cfg_in.slot_recovery_time = csr_data[9:0];
            REG_READ_SAMPLE:   cfg_in.read_sample_time   = csr_data[3:0];
            REG_READ_TAIL:     cfg_in.read_tail_time     = csr_data[9:0];
            REG_CONVERT_WAIT:  cfg_in.convert_wait_time  = csr_data[TIMER_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_low_time     <= 4'd1;
         cfg_ff.reset_low_time     <= 10'd600;
         cfg_ff.reset_release_time <= 10'd500;
         cfg_ff.write_data_time    <= 10'd30;
         cfg_ff.slot_recovery_time <= 10'd10;
         cfg_ff.read_sample_time   <= 4'd10;
         cfg_ff.read_tail_time     <= 10'd20;
         cfg_ff.convert_wait_time  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: src/owtr_core.sv
// Bus sequencer of the temperature reader: phase state machine, tick timer,
// bit shifter and reading conversion, advanced by one tick per step.
// Depends on owtr_pkg.
module owtr_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  start_req,
   input  logic                  line_level,
   input  owtr_pkg::cfg_type     cfg,
   output owtr_pkg::result_type  result
);
   import owtr_pkg::*;

   phase_type          phase_ff,  phase_in;
   logic [TIMER_W-1:0] timer_ff,  timer_in;
   logic [2:0]         bit_ff,    bit_in;
   logic [2:0]         byte_ff,   byte_in;
   logic [7:0]         shift_ff,  shift_in;
   logic [7:0]         low_ff,    low_in;
   logic [15:0]        raw_ff,    raw_in;
   logic [15:0]        scaled_ff, scaled_in;
   logic               drive;
   logic               busy;
   logic               done;
   logic [18:0]        times5;

   always_comb begin
      phase_in  = phase_ff;
      timer_in  = timer_ff;
      bit_in    = bit_ff;
      byte_in   = byte_ff;
      shift_in  = shift_ff;
      low_in    = low_ff;
      raw_in    = raw_ff;
      scaled_in = scaled_ff;
      drive     = 1'b0;
      busy      = 1'b0;
      done      = 1'b0;
      times5    = {1'b0, raw_ff, 2'b00} + {3'b000, raw_ff} + 19'd4;

      if (step) begin
         if (phase_in == PH_IDLE && start_req) begin
            byte_in  = '0;
            bit_in   = '0;
            shift_in = '0;
            phase_in = PH_RST_LOW;
            timer_in = enter_len({10'd0, cfg.reset_low_time});
         end

         if (phase_in != PH_IDLE) begin
            busy = 1'b1;
            if (phase_in == PH_RST_LOW || phase_in == PH_WR_LOW || phase_in == PH_RD_LOW)
               drive = 1'b1;
            else if (phase_in == PH_WR_DATA)
               drive = ~shift_in[0];

            // Read bits arrive LSB first and enter at the top of the shifter.
            if (phase_in == PH_RD_WAIT && timer_in == '0)
               shift_in = {line_level, shift_in[7:1]};

            if (timer_in != '0) begin
               timer_in = timer_in - 1'b1;
            end else begin
               case (phase_in)
                  PH_RST_LOW: begin
                     phase_in = PH_RST_REL;
                     timer_in = enter_len({10'd0, cfg.reset_release_time});
                  end
                  PH_RST_REL: begin
                     shift_in = cmd_byte(byte_in[1:0]);
                     bit_in   = '0;
                     phase_in = PH_WR_LOW;
                     timer_in = enter_len({16'd0, cfg.start_low_time});
                  end
                  PH_WR_LOW: begin
                     phase_in = PH_WR_DATA;
                     timer_in = enter_len({10'd0, cfg.write_data_time});
                  end
                  PH_WR_DATA: begin
                     phase_in = PH_WR_REC;
                     timer_in = enter_len({10'd0, cfg.slot_recovery_time});
                  end
                  PH_WR_REC: begin
                     shift_in = {1'b0, shift_in[7:1]};
                     if (bit_in != 3'd7) begin
                        bit_in   = bit_in + 1'b1;
                        phase_in = PH_WR_LOW;
                        timer_in = enter_len({16'd0, cfg.start_low_time});
                     end else begin
                        bit_in  = '0;
                        byte_in = byte_in + 1'b1;
                        if (byte_in == 3'd2) begin
                           // Convert command sent: wait, or go straight to the
                           // second reset when no wait is set.
                           if (cfg.convert_wait_time != '0) begin
                              phase_in = PH_CONV_WAIT;
                              timer_in = enter_len(cfg.convert_wait_time);
                           end else begin
                              phase_in = PH_RST_LOW;
                              timer_in = enter_len({10'd0, cfg.reset_low_time});
                           end
                        end else if (byte_in >= 3'd4) begin
                           byte_in  = 3'd4;
                           shift_in = '0;
                           phase_in = PH_RD_LOW;
                           timer_in = enter_len({16'd0, cfg.start_low_time});
                        end else begin
                           shift_in = cmd_byte(byte_in[1:0]);
                           bit_in   = '0;
                           phase_in = PH_WR_LOW;
                           timer_in = enter_len({16'd0, cfg.start_low_time});
                        end
                     end
                  end
                  PH_CONV_WAIT: begin
                     phase_in = PH_RST_LOW;
                     timer_in = enter_len({10'd0, cfg.reset_low_time});
                  end
                  PH_RD_LOW: begin
                     phase_in = PH_RD_WAIT;
                     timer_in = enter_len({16'd0, cfg.read_sample_time});
                  end
                  PH_RD_WAIT: begin
                     phase_in = PH_RD_TAIL;
                     timer_in = enter_len({10'd0, cfg.read_tail_time});
                  end
                  PH_RD_TAIL: begin
                     if (bit_in != 3'd7) begin
                        bit_in   = bit_in + 1'b1;
                        phase_in = PH_RD_LOW;
                        timer_in = enter_len({16'd0, cfg.start_low_time});
                     end else if (byte_in == 3'd4) begin
                        low_in   = shift_in;
                        byte_in  = 3'd5;
                        bit_in   = '0;
                        shift_in = '0;
                        phase_in = PH_RD_LOW;
                        timer_in = enter_len({16'd0, cfg.start_low_time});
                     end else begin
                        // Tenths of a degree: floor((5 * raw + 4) / 8).
                        raw_in    = {shift_in, low_in};
                        times5    = {1'b0, raw_in, 2'b00} + {3'b000, raw_in} + 19'd4;
                        scaled_in = times5[18:3];
                        bit_in    = '0;
                        byte_in   = '0;
                        phase_in  = PH_IDLE;
                        timer_in  = '0;
                        done      = 1'b1;
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                     timer_in = '0;
                  end
               endcase
            end
         end
      end
   end

   assign result.drive_low      = drive;
   assign result.busy_res       = busy;
   assign result.done_res       = done;
   assign result.raw_reading    = raw_in;
   assign result.tenths_degrees = scaled_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         timer_ff  <= '0;
         bit_ff    <= '0;
         byte_ff   <= '0;
         shift_ff  <= '0;
         low_ff    <= '0;
         raw_ff    <= '0;
         scaled_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         timer_ff  <= timer_in;
         bit_ff    <= bit_in;
         byte_ff   <= byte_in;
         shift_ff  <= shift_in;
         low_ff    <= low_in;
         raw_ff    <= raw_in;
         scaled_ff <= scaled_in;
      end
   end

endmodule

// File: src/onewire_temperature_reader_top.sv
// Top level of the single-wire bus temperature reader.
// Depends on owtr_pkg, owtr_csr and owtr_core.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid/req_ready    start_req, line_level (one bus tick)
//   rsp_      out        rsp_valid/rsp_ready    drive_low, busy_res, done_res,
//                                               raw_reading, tenths_degrees
//   csr_      in         csr_valid/csr_ready    csr_index, csr_data
//
// Each request transaction is one bus tick and yields exactly one response
// transaction. A tick is taken every clock cycle when the response side keeps
// up; each tick passes through the input register and then the output
// register. The sequencer state advances only when the input register holds a
// tick and the output register is free or being emptied in the same cycle, so
// a stalled response side simply holds everything in place. Reset is
// synchronous and active high; it empties both registers, puts the sequencer
// in idle and loads the configuration reset values. csr_ready is always high.
module onewire_temperature_reader_top (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_start_req,
   input  logic                               req_line_level,

   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_drive_low,
   output logic                               rsp_busy_res,
   output logic                               rsp_done_res,
   output logic [15:0]                        rsp_raw_reading,
   output logic [15:0]                        rsp_tenths_degrees,

   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [owtr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [owtr_pkg::CSR_DATA_W-1:0]    csr_data
);
   import owtr_pkg::*;

   cfg_type    cfg;
   result_type result;

   // Input register: one captured tick.
   logic       in_valid_ff, in_valid_in;
   logic       start_ff,    start_in;
   logic       line_ff,     line_in;

   // Output register: one finished response.
   logic       out_valid_ff, out_valid_in;
   result_type out_ff,       out_in;

   logic       step;

   // The tick in the input register is processed when the output register
   // can take its response this cycle.
   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      start_in    = start_ff;
      line_in     = line_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         start_in    = req_start_req;
         line_in     = req_line_level;
      end

      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (step) begin
         out_valid_in = 1'b1;
         out_in       = result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      line_ff  <= line_in;
      out_ff   <= out_in;
   end

   owtr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   owtr_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .start_req  (start_ff),
      .line_level (line_ff),
      .cfg        (cfg),
      .result     (result)
   );

   assign rsp_valid          = out_valid_ff;
   assign rsp_drive_low      = out_ff.drive_low;
   assign rsp_busy_res       = out_ff.busy_res;
   assign rsp_done_res       = out_ff.done_res;
   assign rsp_raw_reading    = out_ff.raw_reading;
   assign rsp_tenths_degrees = out_ff.tenths_degrees;

endmodule

// File: src/owtr_checker.sv
// Port-level checker for the temperature reader, bound to the top level.
// Depends only on the top level's ports.
module owtr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_drive_low,
   input logic        rsp_busy_res,
   input logic        rsp_done_res,
   input logic [15:0] rsp_raw_reading,
   input logic [15:0] rsp_tenths_degrees
);

   logic        seen_ff, seen_in;
   logic [15:0] last_raw_ff, last_raw_in;
   logic [18:0] times5;

   assign times5 = {1'b0, rsp_raw_reading, 2'b00} + {3'b000, rsp_raw_reading} + 19'd4;

   always_comb begin
      seen_in     = seen_ff;
      last_raw_in = last_raw_ff;
      if (rsp_valid && rsp_ready) begin
         seen_in     = 1'b1;
         last_raw_in = rsp_raw_reading;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= 1'b0;
         last_raw_ff <= '0;
      end else begin
         seen_ff     <= seen_in;
         last_raw_ff <= last_raw_in;
      end
   end

   // The bus is only pulled low and a reading only finishes inside a sequence.
   a_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_drive_low || rsp_done_res) |-> rsp_busy_res)
      else $error("drive or done outside a running sequence");

   // The reported temperature always matches the reported raw value.
   a_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_tenths_degrees == times5[18:3])
      else $error("tenths_degrees does not match raw_reading");

   // The raw value changes only on a response that finishes a sequence.
   a_raw_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && seen_ff && !rsp_done_res |->
         rsp_raw_reading == last_raw_ff)
      else $error("raw_reading changed without a finished reading");

   // A stalled response holds its payload.
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_raw_reading)
         && $stable(rsp_done_res) && $stable(rsp_drive_low))
      else $error("response changed while stalled");

endmodule

bind onewire_temperature_reader_top owtr_checker u_owtr_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_drive_low      (rsp_drive_low),
   .rsp_busy_res       (rsp_busy_res),
   .rsp_done_res       (rsp_done_res),
   .rsp_raw_reading    (rsp_raw_reading),
   .rsp_tenths_degrees (rsp_tenths_degrees)
);
